@@ sv/bat_pkg.sv @@
// Shared types, constants and elaboration-time helpers for the beacon angle
// trilateration block. No dependencies.
package bat_pkg;

  localparam int ANGLE_FRAC_BITS_DEF  = 6;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  // pi/2 in Q30 and 1.0 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Datapath widths of the solve and divide
  localparam int NUM_W = 51;
  localparam int DEN_W = 31;
  localparam int QUO_W = 17;

  // Pipeline depths
  localparam int LANE_LAT   = 5;
  localparam int SOLVE_LAT  = 4;
  localparam int DIV_LAT    = 3 + QUO_W + 1;
  localparam int PIPE_LAT   = LANE_LAT + SOLVE_LAT + DIV_LAT;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_A_X    = 3'd1,
    REG_A_Y    = 3'd2,
    REG_B_X    = 3'd3,
    REG_B_Y    = 3'd4,
    REG_C_X    = 3'd5,
    REG_C_Y    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] range_a;
    logic [15:0] range_b;
    logic [15:0] range_c;
    status_t     status;
  } side_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        range_a;
    logic [15:0]        range_b;
    logic [15:0]        range_c;
    status_t            status;
  } out_item_t;

  // Q16 sine of a Q30 angle: Horner Taylor series to x^13, truncating.
  function automatic logic [16:0] sine_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] d;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      p = (x2 * t) >> 30;
      case (k)
        0:       d = p / 64'd156;
        1:       d = p / 64'd110;
        2:       d = p / 64'd72;
        3:       d = p / 64'd42;
        4:       d = p / 64'd20;
        default: d = p / 64'd6;
      endcase
      t = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    end
    s = (x * t) >> 30;
    s = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return s[16:0];
  endfunction

endpackage

@@ sv/beacon_angle_trilateration.sv @@
// Beacon angle trilateration: three parallel range lanes, a solve stage and
// two pipelined dividers. Every stage is registered; throughput one item per cycle
// while the output queue has credit (in_stall is raised otherwise).
// Sustained rate is held by a 32-entry output queue with credit counting.
// rst (sync, active high) clears handshake state and loads register defaults;
// no clearing pass. Depends on bat_pkg, bat_lane, bat_solve, bat_div, bat_fifo.
module beacon_angle_trilateration #(
  parameter int ANGLE_FRAC_BITS  = bat_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = bat_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [13:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [13:0]        angle_a,
  input  logic [13:0]        angle_b,
  input  logic [13:0]        angle_c,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic [15:0]        range_a,
  output logic [15:0]        range_b,
  output logic [15:0]        range_c,
  output logic [1:0]         status
);

  // ---------------------------------------------------------------------
  // Configuration registers; writes always complete, as cfg_ready is tied high.
  // ---------------------------------------------------------------------
  logic [7:0]         beacon_radius;
  logic signed [13:0] beacon_a_x, beacon_a_y;
  logic signed [13:0] beacon_b_x, beacon_b_y;
  logic signed [13:0] beacon_c_x, beacon_c_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      beacon_radius <= 8'd40;
      beacon_a_x    <= '0;
      beacon_a_y    <= '0;
      beacon_b_x    <= '0;
      beacon_b_y    <= '0;
      beacon_c_x    <= '0;
      beacon_c_y    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (bat_pkg::cfg_reg_t'(cfg_index))
        bat_pkg::REG_RADIUS: beacon_radius <= cfg_data[7:0];
        bat_pkg::REG_A_X:    beacon_a_x    <= cfg_data;
        bat_pkg::REG_A_Y:    beacon_a_y    <= cfg_data;
        bat_pkg::REG_B_X:    beacon_b_x    <= cfg_data;
        bat_pkg::REG_B_Y:    beacon_b_y    <= cfg_data;
        bat_pkg::REG_C_X:    beacon_c_x    <= cfg_data;
        bat_pkg::REG_C_Y:    beacon_c_y    <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Credit counter: items in flight plus items queued. The pipeline never
  // stalls; input stalls only when the queue could not absorb everything.
  // ---------------------------------------------------------------------
  logic                        in_xfer, out_xfer;
  logic [bat_pkg::FIFO_CW-1:0] credits;

  assign in_stall = (credits == bat_pkg::FIFO_CW'(bat_pkg::FIFO_DEPTH));
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + bat_pkg::FIFO_CW'(in_xfer) - bat_pkg::FIFO_CW'(out_xfer);
    end
  end

  // valid tag travels beside the datapath
  logic vpipe [0:bat_pkg::PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bat_pkg::PIPE_LAT; i++) vpipe[i] <= 1'b0;
    end else begin
      vpipe[0] <= in_xfer;
      for (int i = 1; i < bat_pkg::PIPE_LAT; i++) vpipe[i] <= vpipe[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Three range lanes, one per beacon
  // ---------------------------------------------------------------------
  logic [15:0] rng_a, rng_b, rng_c;
  logic        zr_a, zr_b, zr_c;

  bat_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_lane_a (
    .clk(clk), .angle(angle_a), .radius(beacon_radius), .range(rng_a), .zero(zr_a)
  );

  bat_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_lane_b (
    .clk(clk), .angle(angle_b), .radius(beacon_radius), .range(rng_b), .zero(zr_b)
  );

  bat_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_lane_c (
    .clk(clk), .angle(angle_c), .radius(beacon_radius), .range(rng_c), .zero(zr_c)
  );

  // ---------------------------------------------------------------------
  // Merge: solve terms, then two dividers (x and y)
  // ---------------------------------------------------------------------
  logic signed [bat_pkg::NUM_W-1:0] num_x, num_y;
  logic signed [bat_pkg::DEN_W-1:0] det;
  bat_pkg::side_t                   side_s;

  bat_solve u_solve (
    .clk    (clk),
    .range_a(rng_a), .range_b(rng_b), .range_c(rng_c),
    .zero_a (zr_a),  .zero_b (zr_b),  .zero_c (zr_c),
    .ax     (beacon_a_x), .ay(beacon_a_y),
    .bx     (beacon_b_x), .by(beacon_b_y),
    .cx     (beacon_c_x), .cy(beacon_c_y),
    .num_x  (num_x),
    .num_y  (num_y),
    .det    (det),
    .side   (side_s)
  );

  logic signed [15:0] qx, qy;

  bat_div u_div_x (.clk(clk), .num(num_x), .den(det), .quo(qx));
  bat_div u_div_y (.clk(clk), .num(num_y), .den(det), .quo(qy));

  // ranges and status wait out the divider
  bat_pkg::side_t side_p [0:bat_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    side_p[0] <= side_s;
    for (int i = 1; i < bat_pkg::DIV_LAT; i++) side_p[i] <= side_p[i-1];
  end

  bat_pkg::side_t     side_f;
  bat_pkg::out_item_t item;

  assign side_f = side_p[bat_pkg::DIV_LAT-1];

  // position only meaningful for good geometry and nonzero widths
  always_comb begin
    item.pos_x   = (side_f.status == bat_pkg::ST_OK) ? qx : 16'sd0;
    item.pos_y   = (side_f.status == bat_pkg::ST_OK) ? qy : 16'sd0;
    item.range_a = side_f.range_a;
    item.range_b = side_f.range_b;
    item.range_c = side_f.range_c;
    item.status  = side_f.status;
  end

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  bat_pkg::out_item_t head;

  bat_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (vpipe[bat_pkg::PIPE_LAT-1]),
    .din  (item),
    .pop  (out_xfer),
    .valid(out_valid),
    .dout (head)
  );

  assign pos_x   = head.pos_x;
  assign pos_y   = head.pos_y;
  assign range_a = head.range_a;
  assign range_b = head.range_b;
  assign range_c = head.range_c;
  assign status  = head.status;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= bat_pkg::FIFO_CW'(bat_pkg::FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> credits != '0)
    else $error("result offered with no item outstanding");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    vpipe[bat_pkg::PIPE_LAT-1] |-> credits != '0)
    else $error("pipeline finished an item never counted");

endmodule

@@ sv/bat_lane.sv @@
// One range lane: angular width -> sine ROM index -> range R/sin(w/2).
// Depends on bat_pkg.
module bat_lane #(
  parameter int ANGLE_FRAC_BITS  = bat_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = bat_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic [13:0] angle,
  input  logic [7:0]  radius,
  output logic [15:0] range,
  output logic        zero
);

  localparam longint FULL  = longint'(180) << ANGLE_FRAC_BITS;
  localparam longint NMAX  = FULL * SINE_TABLE_DEPTH + FULL / 2;
  localparam int     NW    = $clog2(NMAX + 1);
  localparam longint MUL   = (longint'(1) << NW) / FULL;
  localparam int     MW    = $clog2(MUL + 1);
  localparam int     PW    = NW + MW;
  localparam int     IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  // quarter-wave sine ROM (Q16) and its reciprocal (2^24 / s)
  logic [16:0] rom_s [0:SINE_TABLE_DEPTH];
  logic [24:0] rom_r [0:SINE_TABLE_DEPTH];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] X = (64'(g) * bat_pkg::HALF_PI_Q30
                                 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
    localparam logic [16:0] S = bat_pkg::sine_q16(X);
    localparam logic [63:0] SD = (S == 17'd0) ? 64'd1 : 64'(S);
    localparam logic [24:0] R = (S == 17'd0) ? 25'd0 : 25'((64'd1 << 24) / SD);
    assign rom_s[g] = S;
    assign rom_r[g] = R;
  end

  // stage 1: clamp, scale, reciprocal product
  logic [NW-1:0] a_w, a_c, n;
  logic [NW-1:0] n_q;
  logic [PW-1:0] p_q;

  always_comb begin
    a_w = NW'(angle);
    a_c = (a_w > NW'(FULL)) ? NW'(FULL) : a_w;
    n   = a_c * NW'(SINE_TABLE_DEPTH) + NW'(FULL / 2);
  end

  always_ff @(posedge clk) begin
    n_q <= n;
    p_q <= PW'(n) * PW'(MUL);
  end

  // stage 2: quotient correction -> ROM index
  logic [NW-1:0]    qe, rem, idx_w;
  logic [IDX_W-1:0] idx_q;

  always_comb begin
    qe    = NW'(p_q[PW-1:NW]);
    rem   = n_q - qe * NW'(FULL);
    idx_w = qe + NW'(rem >= NW'(FULL));
    if (idx_w > NW'(SINE_TABLE_DEPTH)) idx_w = NW'(SINE_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    idx_q <= IDX_W'(idx_w);
  end

  // stage 3: ROM read
  logic [16:0] s_q;
  logic [24:0] r_q;

  always_ff @(posedge clk) begin
    s_q <= rom_s[idx_q];
    r_q <= rom_r[idx_q];
  end

  // stage 4: numerator times reciprocal
  logic [23:0] nn;
  logic [23:0] nn_q;
  logic [48:0] pr_q;
  logic [16:0] s2_q;

  assign nn = {radius, 16'd0} + 24'(s_q >> 1);

  always_ff @(posedge clk) begin
    nn_q <= nn;
    pr_q <= 49'(nn) * 49'(r_q);
    s2_q <= s_q;
  end

  // stage 5: correct by one, saturate
  logic [24:0] qe2, rem2;
  logic [25:0] q2;
  logic [15:0] range_next;
  logic        zero_next;

  always_comb begin
    qe2        = pr_q[48:24];
    rem2       = 25'(nn_q) - 25'(qe2 * 25'(s2_q));
    q2         = 26'(qe2) + 26'(rem2 >= 25'(s2_q));
    zero_next  = (s2_q == 17'd0);
    range_next = (zero_next || q2 > 26'd65535) ? 16'hFFFF : q2[15:0];
  end

  always_ff @(posedge clk) begin
    range <= range_next;
    zero  <= zero_next;
  end

endmodule

@@ sv/bat_solve.sv @@
// Merge stage: combines the three lane ranges with beacon geometry into the
// numerators and determinant of the 2x2 solve. Depends on bat_pkg.
module bat_solve (
  input  logic                              clk,
  input  logic [15:0]                       range_a,
  input  logic [15:0]                       range_b,
  input  logic [15:0]                       range_c,
  input  logic                              zero_a,
  input  logic                              zero_b,
  input  logic                              zero_c,
  input  logic signed [13:0]                ax,
  input  logic signed [13:0]                ay,
  input  logic signed [13:0]                bx,
  input  logic signed [13:0]                by,
  input  logic signed [13:0]                cx,
  input  logic signed [13:0]                cy,
  output logic signed [bat_pkg::NUM_W-1:0]  num_x,
  output logic signed [bat_pkg::NUM_W-1:0]  num_y,
  output logic signed [bat_pkg::DEN_W-1:0]  det,
  output bat_pkg::side_t                    side
);

  // geometry, free running from the registers
  logic signed [14:0] dbx, dby, dcx, dcy;
  logic signed [27:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [29:0] pd1, pd2, nba, nca;
  logic signed [bat_pkg::DEN_W-1:0] det_g;

  always_ff @(posedge clk) begin
    dbx   <= 15'(bx) - 15'(ax);
    dby   <= 15'(by) - 15'(ay);
    dcx   <= 15'(cx) - 15'(ax);
    dcy   <= 15'(cy) - 15'(ay);
    sq_ax <= 28'(ax) * 28'(ax);
    sq_ay <= 28'(ay) * 28'(ay);
    sq_bx <= 28'(bx) * 28'(bx);
    sq_by <= 28'(by) * 28'(by);
    sq_cx <= 28'(cx) * 28'(cx);
    sq_cy <= 28'(cy) * 28'(cy);
    pd1   <= 30'(dbx) * 30'(dcy);
    pd2   <= 30'(dby) * 30'(dcx);
    nba   <= (30'(sq_bx) + 30'(sq_by)) - (30'(sq_ax) + 30'(sq_ay));
    nca   <= (30'(sq_cx) + 30'(sq_cy)) - (30'(sq_ax) + 30'(sq_ay));
    det_g <= bat_pkg::DEN_W'(pd1) - bat_pkg::DEN_W'(pd2);
  end

  // item path
  logic [31:0]        sa, sb, sc;
  logic signed [34:0] ab, ac;
  logic signed [49:0] px1, px2, py1, py2;
  logic               z1, z2, z3;
  logic [47:0]        rng_p [0:bat_pkg::SOLVE_LAT-1];
  bat_pkg::status_t   st_q;

  always_ff @(posedge clk) begin
    sa  <= 32'(range_a) * 32'(range_a);
    sb  <= 32'(range_b) * 32'(range_b);
    sc  <= 32'(range_c) * 32'(range_c);
    z1  <= zero_a | zero_b | zero_c;

    ab  <= $signed({3'b000, sa}) - $signed({3'b000, sb}) + 35'(nba);
    ac  <= $signed({3'b000, sa}) - $signed({3'b000, sc}) + 35'(nca);
    z2  <= z1;

    px1 <= 50'(ab) * 50'(dcy);
    px2 <= 50'(ac) * 50'(dby);
    py1 <= 50'(dbx) * 50'(ac);
    py2 <= 50'(dcx) * 50'(ab);
    z3  <= z2;

    num_x <= bat_pkg::NUM_W'(px1) - bat_pkg::NUM_W'(px2);
    num_y <= bat_pkg::NUM_W'(py1) - bat_pkg::NUM_W'(py2);
    det   <= det_g;
    if (z3) begin
      st_q <= bat_pkg::ST_ZERO;
    end else if (det_g == '0) begin
      st_q <= bat_pkg::ST_DEGEN;
    end else begin
      st_q <= bat_pkg::ST_OK;
    end
  end

  // ranges ride along with the solve
  always_ff @(posedge clk) begin
    rng_p[0] <= {range_a, range_b, range_c};
    for (int i = 1; i < bat_pkg::SOLVE_LAT; i++) begin
      rng_p[i] <= rng_p[i-1];
    end
  end

  assign side = bat_pkg::side_t'({rng_p[bat_pkg::SOLVE_LAT-1], st_q});

endmodule

@@ sv/bat_div.sv @@
// Pipelined restoring divider: round(num / (2*den)), ties away from zero,
// saturated to 16 bits signed. One quotient bit per stage. Depends on bat_pkg.
module bat_div (
  input  logic                              clk,
  input  logic signed [bat_pkg::NUM_W-1:0]  num,
  input  logic signed [bat_pkg::DEN_W-1:0]  den,
  output logic signed [15:0]                quo
);

  localparam int QW = bat_pkg::QUO_W;
  localparam int RW = bat_pkg::NUM_W + 1;
  localparam int VW = bat_pkg::DEN_W + 1;

  // magnitudes
  logic [bat_pkg::NUM_W-1:0] an;
  logic [bat_pkg::DEN_W-1:0] ad;
  logic                      neg0, neg1;
  logic [RW-1:0]             dv;
  logic [VW-1:0]             v1;

  always_ff @(posedge clk) begin
    an   <= num[bat_pkg::NUM_W-1] ? bat_pkg::NUM_W'(-num) : bat_pkg::NUM_W'(num);
    ad   <= den[bat_pkg::DEN_W-1] ? bat_pkg::DEN_W'(-den) : bat_pkg::DEN_W'(den);
    neg0 <= num[bat_pkg::NUM_W-1] ^ den[bat_pkg::DEN_W-1];
    dv   <= RW'(an) + RW'(ad);
    v1   <= VW'(ad) << 1;
    neg1 <= neg0;
  end

  logic [RW-1:0] rem_p [0:QW];
  logic [QW-1:0] q_p   [0:QW];
  logic [VW-1:0] v_p   [0:QW];
  logic          neg_p [0:QW];
  logic          ovf_p [0:QW];

  // overflow check: quotient needs more than QW bits
  always_ff @(posedge clk) begin
    ovf_p[0] <= dv >= RW'({v1, {QW{1'b0}}});
    rem_p[0] <= dv;
    q_p[0]   <= '0;
    v_p[0]   <= v1;
    neg_p[0] <= neg1;
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(v_p[j]) << (QW - 1 - j);
    assign ge = rem_p[j] >= sh;
    always_ff @(posedge clk) begin
      rem_p[j+1] <= ge ? rem_p[j] - sh : rem_p[j];
      q_p[j+1]   <= {q_p[j][QW-2:0], ge};
      v_p[j+1]   <= v_p[j];
      neg_p[j+1] <= neg_p[j];
      ovf_p[j+1] <= ovf_p[j];
    end
  end

  logic [QW-1:0] qf;
  assign qf = q_p[QW];

  always_ff @(posedge clk) begin
    if (neg_p[QW]) begin
      quo <= (ovf_p[QW] || qf > QW'(32768)) ? 16'sh8000 : 16'(~qf + 1'b1);
    end else begin
      quo <= (ovf_p[QW] || qf > QW'(32767)) ? 16'sh7FFF : qf[15:0];
    end
  end

endmodule

@@ sv/bat_fifo.sv @@
// Output result queue that decouples the pipeline from a stalling consumer.
// Depends on bat_pkg.
module bat_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bat_pkg::out_item_t din,
  input  logic               pop,
  output logic               valid,
  output bat_pkg::out_item_t dout
);

  bat_pkg::out_item_t mem [0:bat_pkg::FIFO_DEPTH-1];

  logic [bat_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [bat_pkg::FIFO_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + bat_pkg::FIFO_CW'(push) - bat_pkg::FIFO_CW'(pop);
    end
  end

  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

endmodule

@@ sim/testbench.sv @@
// Testbench for beacon_angle_trilateration: directed table, then random
// lidar widths under several beacon layouts, checked against a local model.
// Depends on bat_pkg and the block RTL.
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] REG_UNUSED = 3'd7;   // no register here, write ignored
  localparam int DEPTH = 1024;                 // sine table depth
  localparam longint unsigned FULL_W = 180 << 6; // 180 degrees in width units
  localparam int RAND_PER_PHASE = 190;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [13:0] angle_a = '0, angle_b = '0, angle_c = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [15:0] pos_x, pos_y;
  logic [15:0] range_a, range_b, range_c;
  logic [1:0] status;

  beacon_angle_trilateration dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected fix: what one transfer should produce
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0] ra, rb, rc;
    logic [1:0] st;
  } fix_t;

  fix_t pending_fixes[$];
  int errors = 0;
  bit no_gaps = 0;       // back-to-back stretch on both sides
  int sink_hold = 0;     // long receiver hold-off requested by stimulus

  // local copy of the register file
  logic [7:0] radius_mm = 8'd40;
  longint ax = 0, ay = 0, bx = 0, by = 0, cx = 0, cy = 0;

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Q16 quarter-wave sine, Taylor series in Q30 with truncation
  function automatic longint unsigned sine_entry(longint unsigned idx);
    longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned one = 64'd1 << 30;
    longint unsigned ang, sq, term, dd, s;
    ang = (idx * 64'd1686629713 + DEPTH / 2) / DEPTH;
    sq = (ang * ang) >> 30;
    term = one;
    for (int k = 0; k < 6; k++) begin
      dd = ((sq * term) >> 30) / divs[k];
      term = (dd >= one) ? 0 : one - dd;
    end
    s = (((ang * term) >> 30) + 8192) >> 14;
    return (s > 65536) ? 65536 : s;
  endfunction

  function automatic longint unsigned width_range(logic [13:0] w, ref bit zero);
    longint unsigned clamped, idx, s, r;
    clamped = (w > FULL_W) ? FULL_W : w;
    idx = (clamped * DEPTH + FULL_W / 2) / FULL_W;
    if (idx > DEPTH) idx = DEPTH;
    s = sine_entry(idx);
    if (s == 0) begin
      zero = 1;
      return 65535;
    end
    r = (longint'(radius_mm) * 65536 + s / 2) / s;
    return (r > 65535) ? 65535 : r;
  endfunction

  // num / (2*det), rounded half away from zero, clipped to int16
  function automatic logic signed [15:0] round_div(longint num, longint det);
    longint unsigned an, ad, q;
    an = (num < 0) ? -num : num;
    ad = (det < 0) ? -det : det;
    q = (an + ad) / (2 * ad);
    if ((num < 0) != (det < 0)) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q > 32767) ? 16'h7FFF : 16'(q);
  endfunction

  function automatic fix_t locate(logic [13:0] wa, logic [13:0] wb, logic [13:0] wc);
    fix_t f;
    bit zero;
    longint sa, sb, sc, ka, kb, det;
    zero = 0;
    f.ra = 16'(width_range(wa, zero));
    f.rb = 16'(width_range(wb, zero));
    f.rc = 16'(width_range(wc, zero));
    f.x = 0;
    f.y = 0;
    if (zero) begin
      f.st = bat_pkg::ST_ZERO;
      return f;
    end
    sa = longint'(f.ra) * f.ra;
    sb = longint'(f.rb) * f.rb;
    sc = longint'(f.rc) * f.rc;
    ka = sa - sb + (bx * bx + by * by) - (ax * ax + ay * ay);
    kb = sa - sc + (cx * cx + cy * cy) - (ax * ax + ay * ay);
    det = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    if (det == 0) begin
      f.st = bat_pkg::ST_DEGEN;
      return f;
    end
    f.st = bat_pkg::ST_OK;
    f.x = round_div(ka * (cy - ay) - kb * (by - ay), det);
    f.y = round_div((bx - ax) * kb - (cx - ax) * ka, det);
    return f;
  endfunction

  // One register write; the caller drops cfg_valid after the batch.
  task automatic write_reg(logic [2:0] idx, logic [13:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bat_pkg::REG_RADIUS: radius_mm = val[7:0];
      bat_pkg::REG_A_X: ax = $signed(val);
      bat_pkg::REG_A_Y: ay = $signed(val);
      bat_pkg::REG_B_X: bx = $signed(val);
      bat_pkg::REG_B_Y: by = $signed(val);
      bat_pkg::REG_C_X: cx = $signed(val);
      bat_pkg::REG_C_Y: cy = $signed(val);
      default: ;
    endcase
  endtask

  task automatic load_layout(logic [7:0] r, logic [13:0] v[6]);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_fixes.size() == 0);
    write_reg(bat_pkg::REG_RADIUS, {6'd0, r});
    write_reg(bat_pkg::REG_A_X, v[0]);
    write_reg(bat_pkg::REG_A_Y, v[1]);
    write_reg(bat_pkg::REG_B_X, v[2]);
    write_reg(bat_pkg::REG_B_Y, v[3]);
    write_reg(bat_pkg::REG_C_X, v[4]);
    write_reg(bat_pkg::REG_C_Y, v[5]);
    write_reg(REG_UNUSED, 14'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one measurement; returns after its transfer. A gap lowers valid
  // once at a falling edge, back-to-back items keep it high.
  task automatic send(logic [13:0] wa, logic [13:0] wb, logic [13:0] wc,
                      bit has_fix = 0, fix_t fixed = '{default: 0});
    int gap;
    fix_t want;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    angle_a <= wa;
    angle_b <= wb;
    angle_c <= wc;
    do @(posedge clk); while (in_stall);
    want = has_fix ? fixed : locate(wa, wb, wc);
    pending_fixes = {pending_fixes, want};
  endtask

  function automatic logic [13:0] pick_width();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return 14'($urandom_range(60, 3000));   // beacons at working distance
    if (m == 6) return 14'($urandom_range(0, 8));      // near zero-width quantization
    if (m == 7) return 14'($urandom);                  // whole field, past 180 degrees
    if (m == 8) return 14'($urandom_range(11400, 11520));
    return 14'($urandom_range(0, 11520));
  endfunction

  // Receiver: stall a random count per result, then accept and check.
  initial begin
    int n;
    fix_t f;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 8);
      if (sink_hold > 0) begin
        n = sink_hold;
        sink_hold = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_fixes.size() == 0) begin
        report("unexpected result", status, -1);
      end else begin
        f = pending_fixes.pop_front();
        if (pos_x !== f.x) report("pos_x", pos_x, f.x);
        if (pos_y !== f.y) report("pos_y", pos_y, f.y);
        if (range_a !== f.ra) report("range_a", range_a, f.ra);
        if (range_b !== f.rb) report("range_b", range_b, f.rb);
        if (range_c !== f.rc) report("range_c", range_c, f.rc);
        if (status !== f.st) report("status", status, f.st);
      end
      @(negedge clk);
    end
  end

  // Directed rows run under the reset layout: radius 40, all beacons at the
  // origin, so a row with no width quantizing to zero gives degenerate geometry.
  typedef struct {
    logic [13:0] wa, wb, wc;
    bit known;
    fix_t fix;
  } row_t;

  row_t rows[] = '{
    '{0, 0, 0, 1, '{0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, bat_pkg::ST_ZERO}},
    '{11520, 11520, 11520, 1, '{0, 0, 40, 40, 40, bat_pkg::ST_DEGEN}},
    '{16383, 16383, 16383, 1, '{0, 0, 40, 40, 40, bat_pkg::ST_DEGEN}},   // clamp to 180
    '{5, 11520, 11520, 1, '{0, 0, 16'hFFFF, 40, 40, bat_pkg::ST_ZERO}},  // quantizes to 0
    '{11520, 0, 16383, 1, '{0, 0, 40, 16'hFFFF, 40, bat_pkg::ST_ZERO}},
    '{11520, 11520, 0, 1, '{0, 0, 40, 40, 16'hFFFF, bat_pkg::ST_ZERO}},
    '{6, 6, 6, 0, '{default: 0}},
    '{1, 2, 3, 0, '{default: 0}},
    '{11519, 11521, 8192, 0, '{default: 0}},
    '{5760, 2880, 1440, 0, '{default: 0}},
    '{64, 128, 256, 0, '{default: 0}},
    '{10922, 5461, 15, 0, '{default: 0}},
    '{12, 13, 14, 0, '{default: 0}}
  };

  // Layouts: radius, then ax ay bx by cx cy
  typedef struct {
    logic [7:0] r;
    logic [13:0] v[6];
  } layout_t;

  layout_t layouts[] = '{
    '{100, '{0, 0, 3000, 0, 0, 3000}},
    '{255, '{14'sd8191, 14'sd8191, -14'sd8192, 14'sd8191, -14'sd8192, -14'sd8192}},
    '{1, '{-14'sd8192, -14'sd8192, 14'sd8191, -14'sd8192, 14'sd8191, 14'sd8191}},
    '{0, '{0, 0, 2000, 0, 1000, 1500}},                       // radius zero
    '{40, '{0, 0, 1000, 1000, 2000, 2000}},                   // collinear
    '{60, '{-1500, 200, 1800, -300, 100, 2500}}
  };

  initial begin
    layout_t lay;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send(rows[i].wa, rows[i].wb, rows[i].wc, rows[i].known, rows[i].fix);

    for (int p = 0; p < 8; p++) begin
      if (p < layouts.size()) begin
        lay = layouts[p];
      end else begin
        lay.r = 8'($urandom);
        foreach (lay.v[k]) lay.v[k] = 14'($urandom);
      end
      load_layout(lay.r, lay.v);
      // second layout: hold the receiver long enough to back up the queue
      if (p == 1) sink_hold = 300;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        no_gaps = (n >= RAND_PER_PHASE / 2) && (n < RAND_PER_PHASE / 2 + 40);
        send(pick_width(), pick_width(), pick_width());
      end
      no_gaps = 0;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending_fixes.size() == 0);
    repeat (bat_pkg::PIPE_LAT + 40) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
